### rtl/n_queens_backtrack_solver_defines.svh
// Assertion macros shared by the n-queens solver RTL, clocked on clock and off in reset.
`ifndef N_QUEENS_BACKTRACK_SOLVER_DEFINES_SVH
`define N_QUEENS_BACKTRACK_SOLVER_DEFINES_SVH

// Same-cycle implication.
`define NQB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NQB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Holds whenever the controller sits in the given state.
`define NQB_ASSERT_IN(label, st, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (state_ff == st) |-> (cons)) \
      else $error(msg);

`endif

### rtl/nqb_pkg.sv
// Package for the n-queens solver: sizes, widths and the controller state type.
package nqb_pkg;

   // Largest board the solver handles.
   localparam int MAX_N = 16;

   // Board size / column counter width (holds 0..MAX_N).
   localparam int N_W = $clog2(MAX_N + 1);
   // Row / column index width (holds 0..MAX_N-1).
   localparam int ROW_W = $clog2(MAX_N);
   // Number of diagonals in each direction.
   localparam int DIAG_N = 2 * MAX_N - 1;
   // Diagonal index width.
   localparam int DIAG_W = $clog2(DIAG_N);

   // Search controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BACK,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

### rtl/n_queens_backtrack_solver.sv
// N-queens first-solution solver: backtracking search over a placement memory.
//
//   channel | direction | handshake         | words
//   req     | in        | req_valid/stall   | board_size, one per run
//   rsp     | out       | rsp_valid/stall   | column_index, queen_row, solved, last_of_run
//
// Each row tried in a column is one scan step; a backtrack reads the earlier column's row
// from the placement memory in the scan step, then lifts that queen in the back state.
// After a solution, each result word is read from the placement memory, then presented.
// First solution at N=16 takes about ten thousand placements and backtracks; one request
// at a time. Reset (synchronous) returns the controller to idle; the memory is not cleared.
// A stall on rsp holds the presented word; req is stalled until the run's last word leaves.
`include "n_queens_backtrack_solver_defines.svh"

module n_queens_backtrack_solver (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [nqb_pkg::N_W-1:0]   req_board_size,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [nqb_pkg::ROW_W-1:0] rsp_column_index,
   output logic [nqb_pkg::ROW_W-1:0] rsp_queen_row,
   output logic                      rsp_solved,
   output logic                      rsp_last_of_run
);
   import nqb_pkg::*;

   // Control and search registers.
   state_type          state_ff, state_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic [N_W-1:0]     col_ff, col_in;
   logic [N_W-1:0]     try_ff, try_in;
   logic [MAX_N-1:0]   row_mask_ff, row_mask_in;
   logic [DIAG_N-1:0]  rise_mask_ff, rise_mask_in;
   logic [DIAG_N-1:0]  fall_mask_ff, fall_mask_in;
   logic               solved_ff, solved_in;

   // Placement memory: queen row per column.
   logic [ROW_W-1:0]   place_mem [MAX_N];
   logic               wr_en;
   logic [ROW_W-1:0]   wr_addr;
   logic [ROW_W-1:0]   wr_data;
   logic [ROW_W-1:0]   rd_addr;
   logic [ROW_W-1:0]   rd_data_ff;

   // Square under test and its line indices.
   logic [N_W-1:0]     n_sat;
   logic [N_W-1:0]     row_sel;
   logic [N_W:0]       fall_sum;
   logic [DIAG_W-1:0]  rise_idx;
   logic [DIAG_W-1:0]  fall_idx;
   logic               square_free;
   logic [MAX_N-1:0]   row_bit;
   logic [DIAG_N-1:0]  rise_bit;
   logic [DIAG_N-1:0]  fall_bit;
   logic               last_word;

   // Board size saturated to the largest supported board.
   assign n_sat = (req_board_size > N_W'(MAX_N)) ? N_W'(MAX_N) : req_board_size;

   // Row being placed (scan) or lifted (backtrack).
   assign row_sel  = (state_ff == ST_BACK) ? N_W'(rd_data_ff) : try_ff;
   assign rise_idx = DIAG_W'(row_sel + col_ff);
   assign fall_sum = (N_W+1)'(row_sel) + (N_W+1)'(n_ff) - (N_W+1)'(1) - (N_W+1)'(col_ff);
   assign fall_idx = fall_sum[DIAG_W-1:0];

   assign square_free = !row_mask_ff[row_sel[ROW_W-1:0]] && !rise_mask_ff[rise_idx]
                        && !fall_mask_ff[fall_idx];
   assign row_bit  = MAX_N'(1) << row_sel[ROW_W-1:0];
   assign rise_bit = DIAG_N'(1) << rise_idx;
   assign fall_bit = DIAG_N'(1) << fall_idx;

   // Result word outputs.
   assign last_word        = !solved_ff || ((col_ff + N_W'(1)) == n_ff);
   assign rsp_valid        = (state_ff == ST_SEND);
   assign rsp_column_index = col_ff[ROW_W-1:0];
   assign rsp_queen_row    = solved_ff ? rd_data_ff : '0;
   assign rsp_solved       = solved_ff;
   assign rsp_last_of_run  = last_word;
   assign req_stall        = (state_ff != ST_IDLE);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Search registers (payload, no reset needed).
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      col_ff       <= col_in;
      try_ff       <= try_in;
      row_mask_ff  <= row_mask_in;
      rise_mask_ff <= rise_mask_in;
      fall_mask_ff <= fall_mask_in;
      solved_ff    <= solved_in;
   end

   // Placement memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         place_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= place_mem[rd_addr];
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      col_in       = col_ff;
      try_in       = try_ff;
      row_mask_in  = row_mask_ff;
      rise_mask_in = rise_mask_ff;
      fall_mask_in = fall_mask_ff;
      solved_in    = solved_ff;
      wr_en        = 1'b0;
      wr_addr      = col_ff[ROW_W-1:0];
      wr_data      = try_ff[ROW_W-1:0];
      rd_addr      = col_ff[ROW_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            // New run: clear masks, start at column 0 row 0.
            if (req_valid) begin
               n_in         = n_sat;
               col_in       = '0;
               try_in       = '0;
               row_mask_in  = '0;
               rise_mask_in = '0;
               fall_mask_in = '0;
               if (n_sat == '0) begin
                  solved_in = 1'b0;
                  state_in  = ST_SEND;
               end else begin
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (try_ff >= n_ff) begin
               // Column exhausted: fail at column 0, else back up one column.
               if (col_ff == '0) begin
                  solved_in = 1'b0;
                  state_in  = ST_SEND;
               end else begin
                  col_in   = col_ff - N_W'(1);
                  rd_addr  = ROW_W'(col_ff - N_W'(1));
                  state_in = ST_BACK;
               end
            end else if (square_free) begin
               // Place the queen and record its row.
               wr_en        = 1'b1;
               row_mask_in  = row_mask_ff ^ row_bit;
               rise_mask_in = rise_mask_ff ^ rise_bit;
               fall_mask_in = fall_mask_ff ^ fall_bit;
               if ((col_ff + N_W'(1)) == n_ff) begin
                  col_in    = '0;
                  solved_in = 1'b1;
                  state_in  = ST_READ;
               end else begin
                  col_in = col_ff + N_W'(1);
                  try_in = '0;
               end
            end else begin
               try_in = try_ff + N_W'(1);
            end
         end
         ST_BACK: begin
            // Lift the queen read back from memory, resume at the next row.
            row_mask_in  = row_mask_ff ^ row_bit;
            rise_mask_in = rise_mask_ff ^ rise_bit;
            fall_mask_in = fall_mask_ff ^ fall_bit;
            try_in       = N_W'(rd_data_ff) + N_W'(1);
            state_in     = ST_SCAN;
         end
         ST_READ: begin
            // Read address is col_ff; data lands for the send state.
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + N_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Masks hold one bit per queen placed while scanning.
   `NQB_ASSERT_IN(a_scan_rows, ST_SCAN, $countones(row_mask_ff) == col_ff, "row mask count")
   `NQB_ASSERT_IN(a_scan_rise, ST_SCAN, $countones(rise_mask_ff) == col_ff, "rising mask count")
   // While backtracking the queen being lifted is still counted.
   `NQB_ASSERT_IN(a_back_rows, ST_BACK, $countones(row_mask_ff) == col_ff + 1, "backtrack count")
   // Search column stays inside the board.
   `NQB_ASSERT_IN(a_scan_col, ST_SCAN, col_ff < n_ff, "search column beyond board")
   // An unsolved run is a single last word.
   `NQB_ASSERT_IN(a_fail_last, ST_SEND, solved_ff || (last_word && col_ff == '0), "failure word")
   // A memory read always leads to a presented word.
   `NQB_ASSERT_NEXT(a_read_send, state_ff == ST_READ, rsp_valid, "no word after read")

endmodule
